[hw/rtl/sfs_pkg.sv]
// Shared types and codes for the sprite frame sequencer.
// Holds command and status codes and the controller-to-datapath command bundle.
// No dependencies.
`default_nettype none

package sfs_pkg;

   // Command codes carried by a request transaction
   localparam logic [2:0] CMD_TICK   = 3'd0;
   localparam logic [2:0] CMD_ADD    = 3'd1;
   localparam logic [2:0] CMD_PLAY   = 3'd2;
   localparam logic [2:0] CMD_PAUSE  = 3'd3;
   localparam logic [2:0] CMD_STOP   = 3'd4;
   localparam logic [2:0] CMD_RESET  = 3'd5;
   localparam logic [2:0] CMD_CREATE = 3'd6;
   localparam logic [2:0] CMD_CLEAR  = 3'd7;

   // Status codes returned in a response transaction
   localparam logic [1:0] STAT_OK   = 2'd0;
   localparam logic [1:0] STAT_BAD  = 2'd1;
   localparam logic [1:0] STAT_FULL = 2'd2;

   // Step strobes from controller to datapath
   typedef struct packed {
      logic capture;   // latch request fields
      logic rd_anim;   // read animation entry
      logic rd_frame;  // read frame store
      logic sel_tex;   // frame read at the updated position
      logic update;    // apply the command, write back state
      logic load_rsp;  // load the response register
   } sfs_cmd_type;

endpackage

`default_nettype wire

[hw/rtl/sprite_frame_sequencer.sv]
// Sprite frame sequencer: holds NUM_ANIMS animations of up to MAX_FRAMES frames
// and answers each command with the state of the addressed animation.
//
// Request channel (req_*): one command per transaction - tick, add frame, play,
// pause, stop, rewind, create or clear all - taken when req_valid is high and
// req_stall is low. Response channel (rsp_*): one transaction per command with
// status, current texture, current frame, finished flag and created index.
//
// Each command walks the controller through five steps: read the animation
// entry, read the current frame's duration, apply the command and write back,
// read the texture at the new position, report. A new request is taken only once
// the previous one has reached the response register; the single-port animation
// table and frame store set this sequence.
// The response sits in an output register: while the receiver stalls it holds,
// the next request is still taken and waits in the report step.
// Reset (synchronous) empties the animation table and drops any pending
// response. The frame store is not cleared; only written frames are read.
`default_nettype none

module sprite_frame_sequencer #(
   parameter int NUM_ANIMS  = 16,
   parameter int MAX_FRAMES = 16
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_stall,
   input  wire  [2:0]  req_command,
   input  wire  [3:0]  req_anim_index,
   input  wire  [31:0] req_delta_time,
   input  wire  [31:0] req_texture_id,
   input  wire  [31:0] req_frame_length,
   input  wire         req_loop_flag,
   output logic        rsp_valid,
   input  wire         rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_current_texture,
   output logic [3:0]  rsp_current_frame,
   output logic        rsp_finished,
   output logic [3:0]  rsp_new_index
);
   import sfs_pkg::*;

   sfs_cmd_type dp_cmd;

   // Sequence each transaction
   sfs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .dp_cmd    (dp_cmd)
   );

   // Store animations and compute the report
   sfs_dpath #(
      .NUM_ANIMS  (NUM_ANIMS),
      .MAX_FRAMES (MAX_FRAMES)
   ) u_dpath (
      .clock               (clock),
      .reset               (reset),
      .dp_cmd              (dp_cmd),
      .req_command         (req_command),
      .req_anim_index      (req_anim_index),
      .req_delta_time      (req_delta_time),
      .req_texture_id      (req_texture_id),
      .req_frame_length    (req_frame_length),
      .req_loop_flag       (req_loop_flag),
      .rsp_status          (rsp_status),
      .rsp_current_texture (rsp_current_texture),
      .rsp_current_frame   (rsp_current_frame),
      .rsp_finished        (rsp_finished),
      .rsp_new_index       (rsp_new_index)
   );

endmodule

`default_nettype wire

[hw/rtl/sfs_ctrl.sv]
// Controller state machine of the sprite frame sequencer.
// Sequences one request through read, update and report steps.
// Depends on sfs_pkg.
`default_nettype none

module sfs_ctrl (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  wire                 rsp_stall,
   output sfs_pkg::sfs_cmd_type dp_cmd
);
   import sfs_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_LOAD   = 6'b000010,
      ST_FETCH  = 6'b000100,
      ST_UPDATE = 6'b001000,
      ST_TEXRD  = 6'b010000,
      ST_REPORT = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = reset || (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Next state and step strobes
   always_comb begin
      state_in = state_ff;
      dp_cmd   = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && !reset) begin
               dp_cmd.capture = 1'b1;
               state_in       = ST_LOAD;
            end
         end
         ST_LOAD: begin
            dp_cmd.rd_anim = 1'b1;
            state_in       = ST_FETCH;
         end
         ST_FETCH: begin
            dp_cmd.rd_frame = 1'b1;
            state_in        = ST_UPDATE;
         end
         ST_UPDATE: begin
            dp_cmd.update = 1'b1;
            state_in      = ST_TEXRD;
         end
         ST_TEXRD: begin
            dp_cmd.rd_frame = 1'b1;
            dp_cmd.sel_tex  = 1'b1;
            state_in        = ST_REPORT;
         end
         ST_REPORT: begin
            if (out_free) begin
               dp_cmd.load_rsp = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Hold the response until the receiver takes it
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (dp_cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

[hw/rtl/sfs_dpath.sv]
// Datapath of the sprite frame sequencer.
// Holds the animation table, the frame store, the update logic and the response register.
// Depends on sfs_pkg; driven by sfs_ctrl strobes.
`default_nettype none

module sfs_dpath #(
   parameter int NUM_ANIMS  = 16,
   parameter int MAX_FRAMES = 16
) (
   input  wire                  clock,
   input  wire                  reset,
   input  sfs_pkg::sfs_cmd_type dp_cmd,
   input  wire  [2:0]           req_command,
   input  wire  [3:0]           req_anim_index,
   input  wire  [31:0]          req_delta_time,
   input  wire  [31:0]          req_texture_id,
   input  wire  [31:0]          req_frame_length,
   input  wire                  req_loop_flag,
   output logic [1:0]           rsp_status,
   output logic [31:0]          rsp_current_texture,
   output logic [3:0]           rsp_current_frame,
   output logic                 rsp_finished,
   output logic [3:0]           rsp_new_index
);
   import sfs_pkg::*;

   localparam int DEPTH = NUM_ANIMS * MAX_FRAMES;
   localparam int AW    = (NUM_ANIMS > 1) ? $clog2(NUM_ANIMS) : 1;
   localparam int FW    = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
   localparam int TW    = $clog2(MAX_FRAMES + 1);
   localparam int CW    = $clog2(NUM_ANIMS + 1);
   localparam int DAW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int XW    = (CW > 4) ? CW : 4;

   typedef struct packed {
      logic [31:0]   elapsed;
      logic [FW-1:0] pos;
      logic [TW-1:0] total;
      logic          loop_mode;
      logic          running;
   } entry_type;

   // Memories
   entry_type   anim_mem  [NUM_ANIMS];
   logic [63:0] frame_mem [DEPTH];

   // Latched request
   logic [2:0]  cmd_ff;
   logic [3:0]  idx_ff;
   logic [31:0] dt_ff, tex_ff, len_ff;
   logic        loop_ff;

   // Control state and read data
   logic [CW-1:0] in_use_ff, in_use_in;
   entry_type     ent_ff;
   logic [63:0]   frm_ff;

   // Update results
   entry_type  upd_ff, upd_in;
   logic [1:0] stat_ff, stat_in;
   logic       bad_ff, bad_in;
   logic [3:0] newidx_ff, newidx_in;

   // Response register
   logic [1:0]  rsp_status_ff;
   logic [31:0] rsp_tex_ff;
   logic [3:0]  rsp_frame_ff;
   logic        rsp_fin_ff;
   logic [3:0]  rsp_newidx_ff;

   logic [AW-1:0]  anim_addr;
   logic [DAW-1:0] frame_base, frame_rd_addr, frame_wr_addr;
   logic           good, store_full;
   logic           wr_anim, wr_frame;
   logic [FW-1:0]  pos_c;
   logic [TW-1:0]  pos_c_p1;
   logic [32:0]    sum_wide;
   logic [31:0]    sum_sat;
   logic [FW+3:0]  pos_ext;
   logic [CW+3:0]  n_ext;
   logic [TW-1:0]  upd_pos_t;
   logic           last;
   logic [31:0]    tex_out;

   // Capture request fields
   always_ff @(posedge clock) begin
      if (dp_cmd.capture) begin
         cmd_ff  <= req_command;
         idx_ff  <= req_anim_index;
         dt_ff   <= req_delta_time;
         tex_ff  <= req_texture_id;
         len_ff  <= req_frame_length;
         loop_ff <= req_loop_flag;
      end
   end

   // Address the entry: create works on the next free slot
   assign anim_addr  = (cmd_ff == CMD_CREATE) ? AW'(in_use_ff) : AW'(idx_ff);
   assign good       = (XW'(idx_ff) < XW'(in_use_ff));
   assign store_full = (in_use_ff == CW'(NUM_ANIMS));
   assign frame_base = DAW'(anim_addr) * DAW'(MAX_FRAMES);

   // Clamp position and saturate elapsed time
   assign pos_c    = (TW'(ent_ff.pos) >= ent_ff.total) ? FW'(ent_ff.total - TW'(1))
                                                        : ent_ff.pos;
   assign pos_c_p1 = TW'(pos_c) + TW'(1);
   assign sum_wide = {1'b0, ent_ff.elapsed} + {1'b0, dt_ff};
   assign sum_sat  = sum_wide[32] ? 32'hFFFF_FFFF : sum_wide[31:0];

   assign frame_rd_addr = frame_base + (dp_cmd.sel_tex ? DAW'(upd_ff.pos) : DAW'(pos_c));
   assign frame_wr_addr = frame_base + DAW'(ent_ff.total);

   // Apply the command to the addressed entry
   always_comb begin
      upd_in    = ent_ff;
      stat_in   = STAT_OK;
      bad_in    = 1'b0;
      newidx_in = 4'd0;
      in_use_in = in_use_ff;
      wr_anim   = 1'b0;
      wr_frame  = 1'b0;
      n_ext     = (CW+4)'(in_use_ff);
      case (cmd_ff)
         CMD_CREATE: begin
            if (store_full) begin
               stat_in = STAT_FULL;
               bad_in  = 1'b1;
            end else begin
               upd_in           = '0;
               upd_in.loop_mode = loop_ff;
               wr_anim          = 1'b1;
               in_use_in        = in_use_ff + CW'(1);
               newidx_in        = n_ext[3:0];
            end
         end
         CMD_CLEAR: begin
            in_use_in = '0;
            bad_in    = 1'b1;
         end
         default: begin
            if (!good) begin
               stat_in = STAT_BAD;
               bad_in  = 1'b1;
            end else begin
               wr_anim = 1'b1;
               unique case (cmd_ff)
                  CMD_TICK: begin
                     if (ent_ff.running && ent_ff.total != '0) begin
                        upd_in.pos     = pos_c;
                        upd_in.elapsed = sum_sat;
                        if (sum_sat >= frm_ff[31:0]) begin
                           upd_in.elapsed = '0;
                           if (pos_c_p1 >= ent_ff.total) begin
                              if (ent_ff.loop_mode) begin
                                 upd_in.pos = '0;
                              end else begin
                                 upd_in.pos     = FW'(ent_ff.total - TW'(1));
                                 upd_in.running = 1'b0;
                              end
                           end else begin
                              upd_in.pos = FW'(pos_c_p1);
                           end
                        end
                     end
                  end
                  CMD_ADD: begin
                     if (ent_ff.total >= TW'(MAX_FRAMES)) begin
                        stat_in = STAT_FULL;
                        wr_anim = 1'b0;
                     end else begin
                        wr_frame     = 1'b1;
                        upd_in.total = ent_ff.total + TW'(1);
                     end
                  end
                  CMD_PLAY:  upd_in.running = 1'b1;
                  CMD_PAUSE: upd_in.running = 1'b0;
                  CMD_STOP: begin
                     upd_in.running = 1'b0;
                     upd_in.elapsed = '0;
                     upd_in.pos     = '0;
                  end
                  default: begin
                     upd_in.elapsed = '0;
                     upd_in.pos     = '0;
                  end
               endcase
            end
         end
      endcase
   end

   // Animation table: read one entry, write it back on update
   always_ff @(posedge clock) begin
      if (dp_cmd.rd_anim) begin
         ent_ff <= anim_mem[anim_addr];
      end
      if (dp_cmd.update && wr_anim) begin
         anim_mem[anim_addr] <= upd_in;
      end
   end

   // Frame store: texture in the upper half, duration in the lower half
   always_ff @(posedge clock) begin
      if (dp_cmd.rd_frame) begin
         frm_ff <= frame_mem[frame_rd_addr];
      end
      if (dp_cmd.update && wr_frame) begin
         frame_mem[frame_wr_addr] <= {tex_ff, len_ff};
      end
   end

   // Hold update results for the report step
   always_ff @(posedge clock) begin
      if (dp_cmd.update) begin
         upd_ff    <= upd_in;
         stat_ff   <= stat_in;
         bad_ff    <= bad_in;
         newidx_ff <= newidx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_use_ff <= '0;
      end else if (dp_cmd.update) begin
         in_use_ff <= in_use_in;
      end
   end

   // Form the report of the addressed animation
   assign upd_pos_t = TW'(upd_ff.pos);
   assign pos_ext   = (FW+4)'(upd_ff.pos);
   assign last      = (upd_ff.total == '0) || ((upd_pos_t + TW'(1)) >= upd_ff.total);
   assign tex_out   = (upd_ff.total != '0 && upd_pos_t < upd_ff.total) ? frm_ff[63:32]
                                                                      : 32'd0;

   always_ff @(posedge clock) begin
      if (dp_cmd.load_rsp) begin
         rsp_status_ff <= stat_ff;
         rsp_newidx_ff <= newidx_ff;
         if (bad_ff) begin
            rsp_tex_ff   <= 32'd0;
            rsp_frame_ff <= 4'd0;
            rsp_fin_ff   <= 1'b1;
         end else begin
            rsp_tex_ff   <= tex_out;
            rsp_frame_ff <= pos_ext[3:0];
            rsp_fin_ff   <= !upd_ff.loop_mode && last && !upd_ff.running;
         end
      end
   end

   assign rsp_status          = rsp_status_ff;
   assign rsp_current_texture = rsp_tex_ff;
   assign rsp_current_frame   = rsp_frame_ff;
   assign rsp_finished        = rsp_fin_ff;
   assign rsp_new_index       = rsp_newidx_ff;

endmodule

`default_nettype wire

[tb/sprite_frame_sequencer_tb.sv]
// Testbench for sprite_frame_sequencer: directed table, then random episodes of
// create / add frame / play / tick traffic, scored against an in-bench predictor or, for typed rows, their own view.
// Depends on sfs_pkg and the sprite_frame_sequencer RTL only.
`default_nettype none

module sprite_frame_sequencer_tb;
   import sfs_pkg::*;

   localparam int ANIM_SLOTS   = 16;
   localparam int FRAME_SLOTS  = 16;
   localparam int RANDOM_ITEMS = 1850;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 12;
   localparam int DIR_ROWS     = 21;
   localparam int MAX_REPORTS  = 30;

   // One response transaction, field by field
   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] texture;
      logic [3:0]  frame;
      logic        finished;
      logic [3:0]  new_index;
   } anim_view_type;

   // One directed stimulus row; typed rows carry their own expected view
   typedef struct packed {
      logic [2:0]    cmd;
      logic [3:0]    idx;
      logic [31:0]   dt;
      logic [31:0]   tex;
      logic [31:0]   len;
      logic          lp;
      logic          typed;
      anim_view_type want;
   } dir_row_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [2:0]  req_command;
   logic [3:0]  req_anim_index;
   logic [31:0] req_delta_time;
   logic [31:0] req_texture_id;
   logic [31:0] req_frame_length;
   logic        req_loop_flag;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_status;
   logic [31:0] rsp_current_texture;
   logic [3:0]  rsp_current_frame;
   logic        rsp_finished;
   logic [3:0]  rsp_new_index;

   sprite_frame_sequencer u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_command         (req_command),
      .req_anim_index      (req_anim_index),
      .req_delta_time      (req_delta_time),
      .req_texture_id      (req_texture_id),
      .req_frame_length    (req_frame_length),
      .req_loop_flag       (req_loop_flag),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_status          (rsp_status),
      .rsp_current_texture (rsp_current_texture),
      .rsp_current_frame   (rsp_current_frame),
      .rsp_finished        (rsp_finished),
      .rsp_new_index       (rsp_new_index)
   );

   // Predicted sequencer state
   int unsigned anims_used;
   logic [31:0] acc_time  [ANIM_SLOTS];
   logic [3:0]  cur_pos   [ANIM_SLOTS];
   int unsigned n_frames  [ANIM_SLOTS];
   bit          loops     [ANIM_SLOTS];
   bit          playing   [ANIM_SLOTS];
   logic [31:0] tex_store [ANIM_SLOTS][FRAME_SLOTS];
   logic [31:0] dur_store [ANIM_SLOTS][FRAME_SLOTS];

   anim_view_type pending_views[$];
   dir_row_type   dir_table [DIR_ROWS];
   int            mismatches  = 0;
   int            items_sent  = 0;
   int            send_calm   = 0;
   int            recv_calm   = 0;
   int            stall_left  = 0;

   // Free-running clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Hard stop on a hung handshake
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("CHECK FAILED");
      $finish;
   end

   function automatic anim_view_type bad_view(input logic [1:0] st);
      anim_view_type v;
      v = '0;
      v.status   = st;
      v.finished = 1'b1;
      return v;
   endfunction

   // Report the visible state of one animation
   function automatic anim_view_type view_of(input int unsigned a, input logic [1:0] st);
      anim_view_type v;
      int unsigned   pos;
      int unsigned   tot;
      bit            last;
      pos = cur_pos[a];
      tot = n_frames[a];
      v = '0;
      v.status = st;
      v.texture = (tot != 0 && pos < tot) ? tex_store[a][pos] : 32'd0;
      v.frame = pos[3:0];
      last = (tot == 0) || (pos + 1 >= tot);
      v.finished = !loops[a] && last && !playing[a];
      return v;
   endfunction

   // Apply one command to the predicted state and return the expected response
   function automatic anim_view_type next_anim_view(input logic [2:0] cmd,
                                                    input logic [3:0] idx,
                                                    input logic [31:0] dt,
                                                    input logic [31:0] tex,
                                                    input logic [31:0] len, input logic lp);
      anim_view_type v;
      int unsigned   a;
      int unsigned   pos;
      logic [32:0]   sum;
      logic [31:0]   sat;
      a = idx;
      if (cmd == CMD_CREATE) begin
         if (anims_used >= ANIM_SLOTS) return bad_view(STAT_FULL);
         a = anims_used;
         acc_time[a] = '0;
         cur_pos[a]  = '0;
         n_frames[a] = 0;
         loops[a]    = lp;
         playing[a]  = 1'b0;
         anims_used++;
         v = view_of(a, STAT_OK);
         v.new_index = a[3:0];
         return v;
      end
      if (cmd == CMD_CLEAR) begin
         anims_used = 0;
         return bad_view(STAT_OK);
      end
      if (a >= anims_used) return bad_view(STAT_BAD);
      case (cmd)
         CMD_TICK: begin
            // Accumulate with saturation, advance on reaching the frame duration
            if (playing[a] && n_frames[a] != 0) begin
               pos = cur_pos[a];
               if (pos >= n_frames[a]) pos = n_frames[a] - 1;
               sum = {1'b0, acc_time[a]} + {1'b0, dt};
               sat = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
               acc_time[a] = sat;
               if (sat >= dur_store[a][pos]) begin
                  acc_time[a] = '0;
                  pos++;
                  if (pos >= n_frames[a]) begin
                     if (loops[a]) begin
                        pos = 0;
                     end else begin
                        pos = n_frames[a] - 1;
                        playing[a] = 1'b0;
                     end
                  end
               end
               cur_pos[a] = pos[3:0];
            end
         end
         CMD_ADD: begin
            if (n_frames[a] >= FRAME_SLOTS) return view_of(a, STAT_FULL);
            tex_store[a][n_frames[a]] = tex;
            dur_store[a][n_frames[a]] = len;
            n_frames[a]++;
         end
         CMD_PLAY: playing[a] = 1'b1;
         CMD_PAUSE: playing[a] = 1'b0;
         CMD_STOP: begin
            playing[a] = 1'b0;
            acc_time[a] = '0;
            cur_pos[a] = '0;
         end
         default: begin
            acc_time[a] = '0;
            cur_pos[a] = '0;
         end
      endcase
      return view_of(a, STAT_OK);
   endfunction

   // Idle cycles before the next transaction, with calm stretches of none
   function automatic int draw_idle(inout int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 11) == 0) begin
         calm = $urandom_range(10, 40);
         return 0;
      end
      return $urandom_range(0, 17);
   endfunction

   // Mostly short times so frames advance; now and then any 32-bit value
   function automatic logic [31:0] short_time();
      if ($urandom_range(0, 15) == 0) return $urandom;
      return $urandom_range(0, 32'h0003_0000);
   endfunction

   function automatic logic [3:0] pick_anim();
      if (anims_used == 0) return 4'($urandom_range(0, 15));
      return 4'($urandom_range(0, anims_used - 1));
   endfunction

   function automatic dir_row_type mk_row(input logic [2:0] cmd, input logic [3:0] idx,
                                          input logic [31:0] dt, input logic [31:0] tex,
                                          input logic [31:0] len, input logic lp,
                                          input logic typed, input logic [1:0] st,
                                          input logic [31:0] tex_o, input logic [3:0] fr,
                                          input logic fin, input logic [3:0] ni);
      dir_row_type r;
      r.cmd = cmd;
      r.idx = idx;
      r.dt = dt;
      r.tex = tex;
      r.len = len;
      r.lp = lp;
      r.typed = typed;
      r.want.status = st;
      r.want.texture = tex_o;
      r.want.frame = fr;
      r.want.finished = fin;
      r.want.new_index = ni;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (mismatches < MAX_REPORTS)
         $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
      mismatches++;
   endtask

   // Send one request transaction; hold it until accepted, then record the expectation
   task automatic put_cmd(input logic [2:0] cmd, input logic [3:0] idx, input logic [31:0] dt,
                          input logic [31:0] tex, input logic [31:0] len, input logic lp,
                          input logic typed, input anim_view_type want);
      int            gap;
      anim_view_type v;
      gap = draw_idle(send_calm);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_command      <= cmd;
      req_anim_index   <= idx;
      req_delta_time   <= dt;
      req_texture_id   <= tex;
      req_frame_length <= len;
      req_loop_flag    <= lp;
      do @(posedge clock); while (req_stall !== 1'b0);
      v = next_anim_view(cmd, idx, dt, tex, len, lp);
      if (typed)
         v = want;
      pending_views = {pending_views, v};
      items_sent++;
   endtask

   // Score response transactions and draw the receiver's stall per transaction
   always @(posedge clock) begin : rsp_side
      anim_view_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pending_views.size() == 0) begin
            report_mismatch("unexpected response", {30'd0, rsp_status}, 32'd0);
         end else begin
            want = pending_views.pop_front();
            if (rsp_status !== want.status)
               report_mismatch("status", {30'd0, rsp_status}, {30'd0, want.status});
            if (rsp_current_texture !== want.texture)
               report_mismatch("current_texture", rsp_current_texture, want.texture);
            if (rsp_current_frame !== want.frame)
               report_mismatch("current_frame", {28'd0, rsp_current_frame},
                               {28'd0, want.frame});
            if (rsp_finished !== want.finished)
               report_mismatch("finished", {31'd0, rsp_finished}, {31'd0, want.finished});
            if (rsp_new_index !== want.new_index)
               report_mismatch("new_index", {28'd0, rsp_new_index}, {28'd0, want.new_index});
         end
         stall_left = draw_idle(recv_calm);
         rsp_stall <= (stall_left != 0);
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= (stall_left != 0);
      end
   end

   initial begin
      int         n_new;
      int         add_w;
      int         steps;
      int         r;
      bit         first_pass;
      logic [3:0] a;

      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_command      <= CMD_TICK;
      req_anim_index   <= '0;
      req_delta_time   <= '0;
      req_texture_id   <= '0;
      req_frame_length <= '0;
      req_loop_flag    <= 1'b0;
      anims_used = 0;
      for (int i = 0; i < ANIM_SLOTS; i++) begin
         acc_time[i] = '0;
         cur_pos[i]  = '0;
         n_frames[i] = 0;
         loops[i]    = 1'b0;
         playing[i]  = 1'b0;
      end

      // Directed rows: extremes, every command, the corner cases
      dir_table[0]  = mk_row(CMD_TICK, 4'd0, 32'd0, 32'd0, 32'd0, 1'b0,
                             1'b1, STAT_BAD, 32'd0, 4'd0, 1'b1, 4'd0);
      dir_table[1]  = mk_row(CMD_CREATE, 4'd0, 32'd0, 32'd0, 32'd0, 1'b0,
                             1'b1, STAT_OK, 32'd0, 4'd0, 1'b1, 4'd0);
      dir_table[2]  = mk_row(CMD_ADD, 4'd0, 32'd0, 32'hFFFF_FFFF, 32'h0001_0000, 1'b0,
                             1'b0, STAT_OK, 32'd0, 4'd0, 1'b0, 4'd0);
      dir_table[3]  = mk_row(CMD_ADD, 4'd0, 32'd0, 32'd0, 32'd0, 1'b0,
                             1'b0, STAT_OK, 32'd0, 4'd0, 1'b0, 4'd0);
      dir_table[4]  = mk_row(CMD_PLAY, 4'd0, 32'd0, 32'd0, 32'd0, 1'b0,
                             1'b0, STAT_OK, 32'd0, 4'd0, 1'b0, 4'd0);
      dir_table[5]  = mk_row(CMD_TICK, 4'd0, 32'hFFFF_FFFF, 32'd0, 32'd0, 1'b0,
                             1'b0, STAT_OK, 32'd0, 4'd0, 1'b0, 4'd0);
      dir_table[6]  = mk_row(CMD_TICK, 4'd0, 32'd0, 32'd0, 32'd0, 1'b0,
                             1'b0, STAT_OK, 32'd0, 4'd0, 1'b0, 4'd0);
      dir_table[7]  = mk_row(CMD_CREATE, 4'd0, 32'd0, 32'd0, 32'd0, 1'b1,
                             1'b1, STAT_OK, 32'd0, 4'd0, 1'b0, 4'd1);
      dir_table[8]  = mk_row(CMD_PLAY, 4'd1, 32'd0, 32'd0, 32'd0, 1'b0,
                             1'b0, STAT_OK, 32'd0, 4'd0, 1'b0, 4'd0);
      dir_table[9]  = mk_row(CMD_TICK, 4'd1, 32'h0001_0000, 32'd0, 32'd0, 1'b0,
                             1'b0, STAT_OK, 32'd0, 4'd0, 1'b0, 4'd0);
      dir_table[10] = mk_row(CMD_ADD, 4'd1, 32'd0, 32'hA5A5_5A5A, 32'hFFFF_FFFF, 1'b0,
                             1'b0, STAT_OK, 32'd0, 4'd0, 1'b0, 4'd0);
      dir_table[11] = mk_row(CMD_TICK, 4'd1, 32'hC000_0000, 32'd0, 32'd0, 1'b0,
                             1'b0, STAT_OK, 32'd0, 4'd0, 1'b0, 4'd0);
      dir_table[12] = mk_row(CMD_TICK, 4'd1, 32'hC000_0000, 32'd0, 32'd0, 1'b0,
                             1'b0, STAT_OK, 32'd0, 4'd0, 1'b0, 4'd0);
      dir_table[13] = mk_row(CMD_PAUSE, 4'd1, 32'd0, 32'd0, 32'd0, 1'b0,
                             1'b0, STAT_OK, 32'd0, 4'd0, 1'b0, 4'd0);
      dir_table[14] = mk_row(CMD_TICK, 4'd1, 32'hFFFF_FFFF, 32'd0, 32'd0, 1'b0,
                             1'b0, STAT_OK, 32'd0, 4'd0, 1'b0, 4'd0);
      dir_table[15] = mk_row(CMD_STOP, 4'd0, 32'd0, 32'd0, 32'd0, 1'b0,
                             1'b0, STAT_OK, 32'd0, 4'd0, 1'b0, 4'd0);
      dir_table[16] = mk_row(CMD_RESET, 4'd1, 32'd0, 32'd0, 32'd0, 1'b0,
                             1'b0, STAT_OK, 32'd0, 4'd0, 1'b0, 4'd0);
      dir_table[17] = mk_row(CMD_ADD, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                             1'b1, 1'b1, STAT_BAD, 32'd0, 4'd0, 1'b1, 4'd0);
      dir_table[18] = mk_row(CMD_PLAY, 4'd2, 32'd0, 32'd0, 32'd0, 1'b0,
                             1'b1, STAT_BAD, 32'd0, 4'd0, 1'b1, 4'd0);
      dir_table[19] = mk_row(CMD_CLEAR, 4'd0, 32'd0, 32'd0, 32'd0, 1'b0,
                             1'b1, STAT_OK, 32'd0, 4'd0, 1'b1, 4'd0);
      dir_table[20] = mk_row(CMD_TICK, 4'd0, 32'h0000_8000, 32'd0, 32'd0, 1'b0,
                             1'b1, STAT_BAD, 32'd0, 4'd0, 1'b1, 4'd0);

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIR_ROWS; i++)
         put_cmd(dir_table[i].cmd, dir_table[i].idx, dir_table[i].dt, dir_table[i].tex,
                 dir_table[i].len, dir_table[i].lp, dir_table[i].typed, dir_table[i].want);

      // Random episodes: clear, create a set, then mixed traffic on live animations.
      // The first episode fills the store and one frame list past capacity.
      items_sent = 0;
      first_pass = 1'b1;
      while (items_sent < RANDOM_ITEMS) begin
         put_cmd(CMD_CLEAR, 4'($urandom_range(0, 15)), $urandom, $urandom, $urandom,
                 1'($urandom_range(0, 1)), 1'b0, '0);
         n_new = (first_pass || $urandom_range(0, 4) == 0) ? ANIM_SLOTS + 1
                                                          : $urandom_range(1, 6);
         for (int i = 0; i < n_new; i++)
            put_cmd(CMD_CREATE, 4'($urandom_range(0, 15)), $urandom, $urandom, $urandom,
                    1'($urandom_range(0, 1)), 1'b0, '0);
         if (first_pass) begin
            for (int i = 0; i <= FRAME_SLOTS; i++)
               put_cmd(CMD_ADD, 4'd0, $urandom, $urandom, short_time(),
                       1'($urandom_range(0, 1)), 1'b0, '0);
         end
         add_w = $urandom_range(5, 40);
         steps = $urandom_range(40, 120);
         for (int s = 0; s < steps; s++) begin
            r = $urandom_range(0, 99);
            a = pick_anim();
            if (r < 8) begin
               // Noise: any command but clear, any index, any field value
               put_cmd(3'($urandom_range(0, 6)), 4'($urandom_range(0, 15)), $urandom,
                       $urandom, $urandom, 1'($urandom_range(0, 1)), 1'b0, '0);
            end else if (r < 8 + add_w) begin
               put_cmd(CMD_ADD, a, $urandom, $urandom, short_time(),
                       1'($urandom_range(0, 1)), 1'b0, '0);
            end else begin
               r = $urandom_range(0, 19);
               if (r < 5)
                  put_cmd(CMD_PLAY, a, $urandom, $urandom, $urandom,
                          1'($urandom_range(0, 1)), 1'b0, '0);
               else if (r == 5)
                  put_cmd(CMD_PAUSE, a, $urandom, $urandom, $urandom,
                          1'($urandom_range(0, 1)), 1'b0, '0);
               else if (r == 6)
                  put_cmd(CMD_STOP, a, $urandom, $urandom, $urandom,
                          1'($urandom_range(0, 1)), 1'b0, '0);
               else if (r == 7)
                  put_cmd(CMD_RESET, a, $urandom, $urandom, $urandom,
                          1'($urandom_range(0, 1)), 1'b0, '0);
               else
                  put_cmd(CMD_TICK, a, short_time(), $urandom, $urandom,
                          1'($urandom_range(0, 1)), 1'b0, '0);
            end
         end
         first_pass = 1'b0;
      end
      req_valid <= 1'b0;

      // Drain outstanding responses, then let the pipeline settle
      while (pending_views.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

`default_nettype wire
